### hdl/dwa_pkg.sv
// shared types and constants of the dual distance wind averager
`default_nettype none

package dwa_pkg;

   localparam int DIST_W     = 10;
   localparam int NEAR_W     = 17;
   localparam int DIR_W      = 16;
   localparam int DIV_NUM_W  = 26;
   localparam int DIV_DEN_W  = 10;
   localparam int DIV_STEP_W = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam logic [NEAR_W-1:0] ONE_Q16   = 17'd65536;
   localparam logic [6:0]        DIR_SCALE = 7'd90;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HIGH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_ENABLE = 2'd2;

   localparam logic [DIST_W-1:0] WINDOW_LOW_RESET  = 10'd450;
   localparam logic [DIST_W-1:0] WINDOW_HIGH_RESET = 10'd530;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

### hdl/dwa_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module dwa_div (
   input  wire                 clock,
   input  wire                 reset,
   input  dwa_pkg::div_req_type div_req,
   output dwa_pkg::div_rsp_type div_rsp
);
   import dwa_pkg::*;

   localparam logic [DIV_STEP_W-1:0] LAST_STEP = DIV_STEP_W'(DIV_NUM_W - 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_STEP_W-1:0] step_ff;
   logic [DIV_DEN_W:0]    rem_ff;
   logic [DIV_NUM_W-1:0]  quo_ff;
   logic [DIV_DEN_W-1:0]  den_ff;

   logic [DIV_DEN_W:0]    rem_shift;
   logic                  rem_ge;
   logic [DIV_DEN_W:0]    rem_in;
   logic [DIV_NUM_W-1:0]  quo_in;

   assign rem_shift = {rem_ff[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};
   assign rem_in    = rem_ge ? (rem_shift - {1'b0, den_ff}) : rem_shift;
   assign quo_in    = {quo_ff[DIV_NUM_W-2:0], rem_ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && (step_ff == LAST_STEP);
         if (div_req.start && !busy_ff) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff  <= '0;
            quo_ff  <= div_req.dividend;
            den_ff  <= div_req.divisor;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quo_ff  <= quo_in;
            step_ff <= step_ff + 1'b1;
            busy_ff <= (step_ff != LAST_STEP);
         end
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff))
      else $error("quotient finished without a running division");
   assert property (@(posedge clock) disable iff (reset)
      (div_req.start && !busy_ff) |=> (busy_ff && step_ff == '0))
      else $error("division start not taken");
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < {1'b0, den_ff}))
      else $error("partial remainder out of range");

endmodule

`default_nettype wire

### hdl/dual_distance_wind_averager.sv
// top level: sequencer, window mapping, block sums and result register
`default_nettype none

// Each word on the request channel carries a right and a left raw distance reading. Each
// reading is clamped to the window set by the window_low and window_high registers and
// mapped to a Q1.16 nearness value (65536 nearest). Strength (mean of both) and direction
// (Q8.8 degrees, 0 to 180) are summed over SAMPLES_PER_AVERAGE words, and one response word
// with the truncated block averages follows every completed block. Words taken while
// sensor_enable is 0 are dropped. All divisions go through one shared radix-2 divider: each
// reading that falls inside the window costs one division, and the word that closes a block
// adds the two average divisions, plus any wait for the previous response word to be taken.
// The request side is not ready while a word is in work.
module dual_distance_wind_averager #(
   parameter int SAMPLES_PER_AVERAGE = 8
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [dwa_pkg::REQ_DATA_W-1:0]   req_tdata,  // right_distance, left_distance
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [dwa_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // mean_strength, mean_direction
   input  wire                              csr_we,
   input  wire  [dwa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [dwa_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dwa_pkg::*;

   localparam int STR_SUM_W = NEAR_W + $clog2(SAMPLES_PER_AVERAGE);
   localparam int DIR_SUM_W = DIR_W + $clog2(SAMPLES_PER_AVERAGE);
   localparam int CNT_W     = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_PER_AVERAGE - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NEAR_R,
      ST_WAIT_R,
      ST_NEAR_L,
      ST_WAIT_L,
      ST_ACC,
      ST_AVG_S,
      ST_WAIT_S,
      ST_WAIT_D
   } state_type;

   state_type             state_ff;
   logic [DIST_W-1:0]     win_lo_ff;
   logic [DIST_W-1:0]     win_hi_ff;
   logic                  enable_ff;
   logic [DIST_W-1:0]     right_ff;
   logic [DIST_W-1:0]     left_ff;
   logic [NEAR_W-1:0]     vr_ff;
   logic [NEAR_W-1:0]     vl_ff;
   logic [STR_SUM_W-1:0]  str_sum_ff;
   logic [DIR_SUM_W-1:0]  dir_sum_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [NEAR_W-1:0]     mean_str_ff;
   logic [DIR_W-1:0]      mean_dir_ff;
   logic                  rsp_valid_ff;
   div_req_type           div_req_ff;
   div_rsp_type           div_rsp;

   logic [DIST_W-1:0]     cur_d;
   logic [DIST_W-1:0]     span;
   logic [DIST_W-1:0]     offset;
   logic                  is_far;
   logic                  is_full;
   logic [NEAR_W:0]       pair_sum;
   logic [NEAR_W-1:0]     strength;
   logic [NEAR_W:0]       dir_diff;
   logic [24:0]           dir_prod;
   logic [DIR_W-1:0]      direction;
   logic [NEAR_W-1:0]     div_near;

   assign cur_d   = (state_ff == ST_NEAR_L) ? left_ff : right_ff;
   assign span    = win_hi_ff - win_lo_ff;
   assign offset  = cur_d - win_lo_ff;
   assign is_far  = cur_d > win_hi_ff;
   assign is_full = !is_far && ((cur_d < win_lo_ff) || (span == '0));

   assign pair_sum  = {1'b0, vr_ff} + {1'b0, vl_ff};
   assign strength  = pair_sum[NEAR_W:1];
   assign dir_diff  = {1'b0, vl_ff} + {1'b0, ONE_Q16} - {1'b0, vr_ff};
   assign dir_prod  = 25'(dir_diff) * 25'(DIR_SCALE);
   assign direction = dir_prod[23:8];
   assign div_near  = ONE_Q16 - div_rsp.quotient[NEAR_W-1:0];

   dwa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         win_lo_ff        <= WINDOW_LOW_RESET;
         win_hi_ff        <= WINDOW_HIGH_RESET;
         enable_ff        <= 1'b1;
         str_sum_ff       <= '0;
         dir_sum_ff       <= '0;
         count_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW_LOW:    win_lo_ff <= csr_wdata[DIST_W-1:0];
               CSR_WINDOW_HIGH:   win_hi_ff <= csr_wdata[DIST_W-1:0];
               CSR_SENSOR_ENABLE: enable_ff <= csr_wdata[0];
               default:           ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               div_req_ff.start <= 1'b0;
               if (req_tvalid && enable_ff) begin
                  right_ff <= req_tdata[DIST_W-1:0];
                  left_ff  <= req_tdata[2*DIST_W-1:DIST_W];
                  state_ff <= ST_NEAR_R;
               end
            end
            ST_NEAR_R, ST_NEAR_L: begin
               if (is_far || is_full) begin
                  div_req_ff.start <= 1'b0;
                  if (state_ff == ST_NEAR_R) begin
                     vr_ff    <= is_far ? '0 : ONE_Q16;
                     state_ff <= ST_NEAR_L;
                  end else begin
                     vl_ff    <= is_far ? '0 : ONE_Q16;
                     state_ff <= ST_ACC;
                  end
               end else begin
                  div_req_ff.start    <= 1'b1;
                  div_req_ff.dividend <= {offset, 16'b0};
                  div_req_ff.divisor  <= span;
                  state_ff <= (state_ff == ST_NEAR_R) ? ST_WAIT_R : ST_WAIT_L;
               end
            end
            ST_WAIT_R: begin
               div_req_ff.start <= 1'b0;
               if (div_rsp.done) begin
                  vr_ff    <= div_near;
                  state_ff <= ST_NEAR_L;
               end
            end
            ST_WAIT_L: begin
               div_req_ff.start <= 1'b0;
               if (div_rsp.done) begin
                  vl_ff    <= div_near;
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               div_req_ff.start <= 1'b0;
               str_sum_ff <= str_sum_ff + STR_SUM_W'(strength);
               dir_sum_ff <= dir_sum_ff + DIR_SUM_W'(direction);
               if (count_ff == LAST_COUNT) begin
                  state_ff <= ST_AVG_S;
               end else begin
                  count_ff <= count_ff + 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_AVG_S: begin
               div_req_ff.start <= !rsp_valid_ff;
               if (!rsp_valid_ff) begin
                  div_req_ff.dividend <= DIV_NUM_W'(str_sum_ff);
                  div_req_ff.divisor  <= DIV_DEN_W'(SAMPLES_PER_AVERAGE);
                  state_ff <= ST_WAIT_S;
               end
            end
            ST_WAIT_S: begin
               div_req_ff.start <= div_rsp.done;
               if (div_rsp.done) begin
                  mean_str_ff         <= div_rsp.quotient[NEAR_W-1:0];
                  div_req_ff.dividend <= DIV_NUM_W'(dir_sum_ff);
                  div_req_ff.divisor  <= DIV_DEN_W'(SAMPLES_PER_AVERAGE);
                  state_ff <= ST_WAIT_D;
               end
            end
            ST_WAIT_D: begin
               div_req_ff.start <= 1'b0;
               if (div_rsp.done) begin
                  mean_dir_ff  <= div_rsp.quotient[DIR_W-1:0];
                  rsp_valid_ff <= 1'b1;
                  str_sum_ff   <= '0;
                  dir_sum_ff   <= '0;
                  count_ff     <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               div_req_ff.start <= 1'b0;
               state_ff         <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, mean_dir_ff, mean_str_ff};

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WAIT_D))
      else $error("response word raised outside the direction average");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && count_ff == '0) |-> (str_sum_ff == '0 && dir_sum_ff == '0))
      else $error("block sums not cleared at block start");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_COUNT)
      else $error("sample count beyond block length");
   assert property (@(posedge clock) disable iff (reset)
      div_req_ff.start |-> !div_rsp.busy)
      else $error("division requested while divider busy");

endmodule

`default_nettype wire

### verif/dwa_checker.sv
// checker: watches the register port and both channels, predicts the block means and compares
`timescale 1ns / 100ps

module dwa_checker #(
   parameter int SAMPLES_PER_AVERAGE = 8
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   input  wire                              req_tready,
   input  wire  [dwa_pkg::REQ_DATA_W-1:0]   req_tdata,  // right_distance, left_distance
   input  wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   input  wire  [dwa_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // mean_strength, mean_direction
   input  wire                              csr_we,
   input  wire  [dwa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [dwa_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               fail_count,
   output int                               pending_means,
   output int                               taken_words,
   output int                               dropped_words,
   output int                               checked_means
);
   import dwa_pkg::*;

   typedef struct packed {
      logic [NEAR_W-1:0] strength;
      logic [DIR_W-1:0]  direction;
   } wind_mean_type;

   wind_mean_type     expected_means[$];
   logic [DIST_W-1:0] window_low;
   logic [DIST_W-1:0] window_high;
   logic              sensor_enable;
   int unsigned       strength_sum;
   int unsigned       direction_sum;
   int unsigned       sample_count;

   initial begin
      fail_count    = 0;
      pending_means = 0;
      taken_words   = 0;
      dropped_words = 0;
      checked_means = 0;
   end

   // q1.16 nearness of one raw reading, 65536 nearest
   function automatic int unsigned nearness(input logic [DIST_W-1:0] reading);
      int unsigned d;
      int unsigned lo;
      int unsigned hi;
      int unsigned z;
      d  = 32'(reading);
      lo = 32'(window_low);
      hi = 32'(window_high);
      if (d > hi) begin
         z = 32'(ONE_Q16);
      end else if (d < lo) begin
         z = 0;
      end else if (hi == lo) begin
         z = 0;
      end else begin
         z = ((d - lo) * ONE_Q16) / (hi - lo);
      end
      return ONE_Q16 - z;
   endfunction

   task automatic accumulate_reading(input logic [DIST_W-1:0] right,
                                     input logic [DIST_W-1:0] left);
      int unsigned   near_right;
      int unsigned   near_left;
      wind_mean_type mean;
      if (!sensor_enable) begin
         dropped_words++;
         return;
      end
      taken_words++;
      near_right = nearness(right);
      near_left  = nearness(left);
      strength_sum  += (near_right + near_left) >> 1;
      direction_sum += ((near_left + ONE_Q16 - near_right) * DIR_SCALE) >> 8;
      if (sample_count + 1 >= SAMPLES_PER_AVERAGE) begin
         mean.strength  = NEAR_W'(strength_sum / SAMPLES_PER_AVERAGE);
         mean.direction = DIR_W'(direction_sum / SAMPLES_PER_AVERAGE);
         expected_means = {expected_means, mean};
         strength_sum  = 0;
         direction_sum = 0;
         sample_count  = 0;
      end else begin
         sample_count++;
      end
   endtask

   task automatic compare_mean(input wind_mean_type actual);
      wind_mean_type expected;
      if (expected_means.size() == 0) begin
         $display("%0t: unexpected word: expected none, actual strength %0d direction %0d",
                  $time, actual.strength, actual.direction);
         fail_count++;
         return;
      end
      expected = expected_means.pop_front();
      checked_means++;
      if (actual.strength !== expected.strength) begin
         $display("%0t: mean_strength mismatch: expected %0d, actual %0d",
                  $time, expected.strength, actual.strength);
         fail_count++;
      end
      if (actual.direction !== expected.direction) begin
         $display("%0t: mean_direction mismatch: expected %0d, actual %0d",
                  $time, expected.direction, actual.direction);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_low    = WINDOW_LOW_RESET;
         window_high   = WINDOW_HIGH_RESET;
         sensor_enable = 1'b1;
         strength_sum  = 0;
         direction_sum = 0;
         sample_count  = 0;
         expected_means.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW_LOW: begin
                  window_low = csr_wdata[DIST_W-1:0];
               end
               CSR_WINDOW_HIGH: begin
                  window_high = csr_wdata[DIST_W-1:0];
               end
               CSR_SENSOR_ENABLE: begin
                  sensor_enable = csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            accumulate_reading(req_tdata[DIST_W-1:0], req_tdata[2*DIST_W-1:DIST_W]);
         end
         if (rsp_tvalid && rsp_tready) begin
            compare_mean({rsp_tdata[NEAR_W-1:0], rsp_tdata[NEAR_W+DIR_W-1:NEAR_W]});
         end
      end
      pending_means = expected_means.size();
   end

endmodule

### verif/tb_top.sv
// testbench top: clock, reset, register writes, request stimulus, response stalls and verdict
`timescale 1ns / 100ps

module tb_top;
   import dwa_pkg::*;

   localparam int                   SAMPLES     = 8;
   localparam int                   SETTLE      = 80;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // right_distance, left_distance
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // mean_strength, mean_direction
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int fail_count;
   int pending_means;
   int taken_words;
   int dropped_words;
   int checked_means;

   int                tx_idle_pct = 0;
   int                rx_idle_pct = 0;
   int                reg_writes  = 0;
   int                counted     = 0;
   logic [DIST_W-1:0] cur_low     = WINDOW_LOW_RESET;
   logic [DIST_W-1:0] cur_high    = WINDOW_HIGH_RESET;
   logic              cur_enable  = 1'b1;

   dual_distance_wind_averager #(
      .SAMPLES_PER_AVERAGE(SAMPLES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   dwa_checker #(
      .SAMPLES_PER_AVERAGE(SAMPLES)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_means (pending_means),
      .taken_words   (taken_words),
      .dropped_words (dropped_words),
      .checked_means (checked_means)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
   end

   initial begin
      #3000000;
      $display("Verification failed");
      $finish;
   end

   task automatic send_word(input logic [DIST_W-1:0] right, input logic [DIST_W-1:0] left);
      while ($urandom_range(99, 0) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-2*DIST_W){1'b0}}, left, right};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (cur_enable) begin
         counted++;
      end
   endtask

   // block is idle once every mean is in and the last word has had time to finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_means != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      reg_writes++;
      case (index)
         CSR_WINDOW_LOW: begin
            cur_low = data[DIST_W-1:0];
         end
         CSR_WINDOW_HIGH: begin
            cur_high = data[DIST_W-1:0];
         end
         CSR_SENSOR_ENABLE: begin
            cur_enable = data[0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic set_window(input logic [DIST_W-1:0] low, input logic [DIST_W-1:0] high);
      wait_idle();
      write_reg(CSR_WINDOW_LOW, low);
      write_reg(CSR_WINDOW_HIGH, high);
   endtask

   task automatic set_enable(input logic on);
      wait_idle();
      write_reg(CSR_SENSOR_ENABLE, {(CSR_DATA_W-1)'($urandom), on});
   endtask

   // mostly readings on the window edges or inside the window widened by 3, some over the full range
   function automatic logic [DIST_W-1:0] pick_distance();
      int a;
      int b;
      a = int'((cur_low < cur_high) ? cur_low : cur_high);
      b = int'((cur_low < cur_high) ? cur_high : cur_low);
      a = (a > 3) ? a - 3 : 0;
      b = (b < 1020) ? b + 3 : 1023;
      case ($urandom_range(3, 0))
         0: return DIST_W'($urandom_range(1023, 0));
         1: return $urandom_range(1, 0) ? cur_low : cur_high;
         default: return DIST_W'($urandom_range(b, a));
      endcase
   endfunction

   task automatic random_window();
      int lo;
      int hi;
      case ($urandom_range(5, 0))
         0: begin
            lo = int'(WINDOW_LOW_RESET);
            hi = int'(WINDOW_HIGH_RESET);
         end
         1: begin
            lo = 0;
            hi = 1023;
         end
         2: begin
            lo = $urandom_range(1023, 0);
            hi = lo;
         end
         3: begin
            hi = $urandom_range(1022, 0);
            lo = $urandom_range(1023, hi + 1);
         end
         4: begin
            lo = $urandom_range(1022, 0);
            hi = $urandom_range(1023, lo + 1);
         end
         default: begin
            lo = $urandom_range(1013, 0);
            hi = lo + $urandom_range(10, 1);
         end
      endcase
      set_window(DIST_W'(lo), DIST_W'(hi));
   endtask

   initial begin
      int phase;
      int target;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default window, extremes and edges
      send_word(10'd0, 10'd1023);
      send_word(10'd1023, 10'd0);
      send_word(10'd450, 10'd530);
      send_word(10'd530, 10'd450);
      send_word(10'd449, 10'd531);
      send_word(10'd451, 10'd529);
      send_word(10'd490, 10'd490);
      send_word(10'd1023, 10'd1023);

      // window change in the middle of a block
      send_word(10'd0, 10'd0);
      send_word(10'd500, 10'd460);
      send_word(10'd1023, 10'd512);
      set_window(10'd0, 10'd1023);
      send_word(10'd0, 10'd1023);
      send_word(10'd1023, 10'd0);
      send_word(10'd511, 10'd512);
      send_word(10'd1, 10'd1022);
      send_word(10'd512, 10'd511);

      // zero span
      set_window(10'd600, 10'd600);
      send_word(10'd600, 10'd600);
      send_word(10'd599, 10'd601);
      send_word(10'd601, 10'd599);

      // inverted window
      set_window(10'd700, 10'd300);
      send_word(10'd300, 10'd301);
      send_word(10'd700, 10'd299);

      // disabled words are dropped, unmapped index leaves the window alone
      set_enable(1'b0);
      send_word(10'd1023, 10'd0);
      send_word(10'd0, 10'd1023);
      send_word(10'd345, 10'd678);
      wait_idle();
      write_reg(CSR_UNUSED, 10'h3FF);
      set_enable(1'b1);
      send_word(10'd1023, 10'd0);
      send_word(10'd500, 10'd500);
      send_word(10'd0, 10'd0);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 36;
               rx_idle_pct = 61;
            end
            1: begin
               tx_idle_pct = 61;
               rx_idle_pct = 36;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         target = counted + 667;
         while (counted < target) begin
            random_window();
            if ($urandom_range(3, 0) == 0) begin
               set_enable(1'b0);
               repeat ($urandom_range(4, 1)) send_word(pick_distance(), pick_distance());
               set_enable(1'b1);
            end
            repeat ($urandom_range(60, 16)) send_word(pick_distance(), pick_distance());
         end
      end

      wait_idle();
      $display("Summary: %0d request words processed, %0d dropped while disabled",
               taken_words, dropped_words);
      $display("Summary: %0d means checked, %0d register writes over default, full,",
               checked_means, reg_writes);
      $display("         zero-span, inverted and narrow windows");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
